// ----- rtl/core/cc_pkg.sv -----
// Shared types, constants and ChaCha round functions for the keystream block.
// Used by cc_front, cc_fifo, cc_core and chacha20_keystream_block.
// No dependencies.
`timescale 1ns / 1ps

package cc_pkg;

    localparam int ROUNDS_DEFAULT   = 20;
    localparam int REQ_QUEUE_DEPTH  = 2;
    localparam int NUM_WORDS        = 16;
    localparam int WORDS_PER_BLOCK  = 8;
    localparam int CFG_ADDR_W       = 6;
    localparam int CFG_DATA_W       = 64;

    localparam logic [2:0] LAST_WORD_IDX = 3'(WORDS_PER_BLOCK - 1);

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // Register indexes on the configuration port (byte address is 8 * index).
    typedef enum logic [2:0] {
        REG_KEY_BITS_0     = 3'd0,
        REG_KEY_BITS_1     = 3'd1,
        REG_KEY_BITS_2     = 3'd2,
        REG_KEY_BITS_3     = 3'd3,
        REG_NONCE_LOW      = 3'd4,
        REG_NONCE_HIGH     = 3'd5,
        REG_COUNTER_STEP   = 3'd6
    } cc_reg_idx_t;

    typedef logic [31:0] cc_word_t;
    typedef logic [NUM_WORDS-1:0][31:0] cc_state_t;

    typedef struct packed {
        logic [63:0] key_bits_0;
        logic [63:0] key_bits_1;
        logic [63:0] key_bits_2;
        logic [63:0] key_bits_3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
    } cc_cfg_t;

    // Request queue write side, front to queue.
    typedef struct packed {
        logic     wr_en;
        cc_word_t counter;
    } cc_req_t;

    function automatic cc_state_t cc_quarter(input cc_state_t s, input logic [3:0] a,
                                             input logic [3:0] b, input logic [3:0] c,
                                             input logic [3:0] d);
        cc_state_t r;
        cc_word_t  va;
        cc_word_t  vb;
        cc_word_t  vc;
        cc_word_t  vd;
        r  = s;
        va = s[a] + s[b];
        vd = s[d] ^ va;
        vd = {vd[15:0], vd[31:16]};
        vc = s[c] + vd;
        vb = s[b] ^ vc;
        vb = {vb[19:0], vb[31:20]};
        va = va + vb;
        vd = vd ^ va;
        vd = {vd[23:0], vd[31:24]};
        vc = vc + vd;
        vb = vb ^ vc;
        vb = {vb[24:0], vb[31:25]};
        r[a] = va;
        r[b] = vb;
        r[c] = vc;
        r[d] = vd;
        return r;
    endfunction

    // One round: the four quarter-rounds touch disjoint words, so they run side by side.
    function automatic cc_state_t cc_round(input cc_state_t s, input logic diagonal);
        cc_state_t r;
        r = s;
        if (!diagonal) begin
            r = cc_quarter(r, 4'd0, 4'd4, 4'd8,  4'd12);
            r = cc_quarter(r, 4'd1, 4'd5, 4'd9,  4'd13);
            r = cc_quarter(r, 4'd2, 4'd6, 4'd10, 4'd14);
            r = cc_quarter(r, 4'd3, 4'd7, 4'd11, 4'd15);
        end
        else begin
            r = cc_quarter(r, 4'd0, 4'd5, 4'd10, 4'd15);
            r = cc_quarter(r, 4'd1, 4'd6, 4'd11, 4'd12);
            r = cc_quarter(r, 4'd2, 4'd7, 4'd8,  4'd13);
            r = cc_quarter(r, 4'd3, 4'd4, 4'd9,  4'd14);
        end
        return r;
    endfunction

    function automatic cc_state_t cc_init(input cc_cfg_t cfg, input cc_word_t counter);
        cc_state_t s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        s[4]  = cfg.key_bits_0[31:0];
        s[5]  = cfg.key_bits_0[63:32];
        s[6]  = cfg.key_bits_1[31:0];
        s[7]  = cfg.key_bits_1[63:32];
        s[8]  = cfg.key_bits_2[31:0];
        s[9]  = cfg.key_bits_2[63:32];
        s[10] = cfg.key_bits_3[31:0];
        s[11] = cfg.key_bits_3[63:32];
        s[12] = counter;
        s[13] = cfg.nonce_low[31:0];
        s[14] = cfg.nonce_low[63:32];
        s[15] = cfg.nonce_high;
        return s;
    endfunction

endpackage

// ----- rtl/core/chacha20_keystream_block.sv -----
// ChaCha keystream block generator: 64-byte blocks as eight 64-bit words per request.
// Requests are queued; the single round unit does one round per cycle and works one block
// at a time; a block starts from idle or as the last word of the one before is popped.
// Reset (rst_n, asynchronous, active low) clears the configuration, the counter, the engine
// state and the queue pointers; the round data and the queue storage are not reset.
// Depends on cc_pkg, cc_front, cc_fifo and cc_core.
`timescale 1ns / 1ps

module chacha20_keystream_block
#(
    parameter int ROUNDS      = cc_pkg::ROUNDS_DEFAULT,
    parameter int QUEUE_DEPTH = cc_pkg::REQ_QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration port, APB style. Register i sits at byte address 8 * i.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,

    // Request side, seen as the write end of a queue.
    input  logic                          push,
    output logic                          full,
    input  logic                          load_counter,
    input  logic [31:0]                   counter_value,

    // Result side, seen as the read end of a queue.
    output logic                          empty,
    input  logic                          pop,
    output logic [63:0]                   keystream_word,
    output logic [2:0]                    word_index,
    output logic                          last_word
);

    // ------------------------------------------------------------------
    // Configuration registers. A write lands on the access phase of an APB
    // transaction; indexes past the last register are ignored. The port
    // never inserts wait states.
    // ------------------------------------------------------------------
    logic                cfg_wr;
    cc_pkg::cc_reg_idx_t cfg_idx;
    cc_pkg::cc_cfg_t     cfg_reg;
    cc_pkg::cc_cfg_t     cfg_next;
    logic                auto_inc_reg;
    logic                auto_inc_next;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cc_pkg::cc_reg_idx_t'(paddr[5:3]);

    always_comb
    begin
        cfg_next      = cfg_reg;
        auto_inc_next = auto_inc_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                cc_pkg::REG_KEY_BITS_0:     cfg_next.key_bits_0 = pwdata;
                cc_pkg::REG_KEY_BITS_1:     cfg_next.key_bits_1 = pwdata;
                cc_pkg::REG_KEY_BITS_2:     cfg_next.key_bits_2 = pwdata;
                cc_pkg::REG_KEY_BITS_3:     cfg_next.key_bits_3 = pwdata;
                cc_pkg::REG_NONCE_LOW:      cfg_next.nonce_low  = pwdata;
                cc_pkg::REG_NONCE_HIGH:     cfg_next.nonce_high = pwdata[31:0];
                cc_pkg::REG_COUNTER_STEP:   auto_inc_next       = pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg      <= '0;
            auto_inc_reg <= 1'b0;
        end
        else begin
            cfg_reg      <= cfg_next;
            auto_inc_reg <= auto_inc_next;
        end
    end

    // Read-back multiplexer; narrower registers are zero-extended.
    always_comb
    begin
        case (cfg_idx)
            cc_pkg::REG_KEY_BITS_0:     prdata = cfg_reg.key_bits_0;
            cc_pkg::REG_KEY_BITS_1:     prdata = cfg_reg.key_bits_1;
            cc_pkg::REG_KEY_BITS_2:     prdata = cfg_reg.key_bits_2;
            cc_pkg::REG_KEY_BITS_3:     prdata = cfg_reg.key_bits_3;
            cc_pkg::REG_NONCE_LOW:      prdata = cfg_reg.nonce_low;
            cc_pkg::REG_NONCE_HIGH:     prdata = {32'd0, cfg_reg.nonce_high};
            cc_pkg::REG_COUNTER_STEP:   prdata = {63'd0, auto_inc_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: takes a request, settles which block counter it uses and stores it plus
    // the counter step as the next counter. Only that counter travels on through the request
    // queue; the user must keep key and nonce stable while work is in flight (unchecked).
    // ------------------------------------------------------------------
    cc_pkg::cc_req_t req;
    logic [31:0]     front_counter;
    logic            q_empty;
    logic            q_pop;
    logic [31:0]     q_data;

    cc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .load_counter   (load_counter),
        .counter_value  (counter_value),
        .counter_step   (auto_inc_reg),
        .req            (req),
        .block_counter  (front_counter)
    );

    // The queue lets further requests be taken while the engine is busy
    // or while its words wait to be popped.
    cc_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    // ------------------------------------------------------------------
    // Back end: loads the initial state, runs the rounds, adds the initial
    // state back in and presents the block one 64-bit word at a time. If a request
    // is queued, a new block is loaded in the same cycle that the last word is popped.
    // ------------------------------------------------------------------
    cc_core
    #(
        .ROUNDS (ROUNDS)
    )
    u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .keystream_word (keystream_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> !full)
        else $error("request written into a full queue");

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_word) |=>
            (!empty && word_index == $past(word_index) + 3'd1))
        else $error("keystream words out of order within a block");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !load_counter && auto_inc_reg) |=>
            (front_counter == $past(front_counter) + 32'd1))
        else $error("block counter did not advance after a transaction");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_word && q_empty) |=> empty)
        else $error("words shown with no block in progress");

endmodule

// ----- rtl/core/cc_front.sv -----
// Request front end: accepts requests and resolves the block counter for each.
// Depends on cc_pkg.
`timescale 1ns / 1ps

module cc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               load_counter,
    input  logic [31:0]        counter_value,
    input  logic               counter_step,
    output cc_pkg::cc_req_t    req,
    output logic [31:0]        block_counter
);

    logic        accept;
    logic [31:0] used_counter;
    logic [31:0] block_counter_reg;
    logic [31:0] block_counter_next;

    assign accept       = push && !full;
    assign used_counter = load_counter ? counter_value : block_counter_reg;

    // A loaded value serves this block and is then stepped like a stored one.
    always_comb
    begin
        block_counter_next = block_counter_reg;
        if (accept) begin
            block_counter_next = used_counter + {31'd0, counter_step};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            block_counter_reg <= '0;
        end
        else begin
            block_counter_reg <= block_counter_next;
        end
    end

    assign req.wr_en   = accept;
    assign req.counter = used_counter;
    assign block_counter = block_counter_reg;

endmodule

// ----- rtl/core/cc_fifo.sv -----
// Small request queue between the front end and the round engine.
// Depends on cc_pkg.
`timescale 1ns / 1ps

module cc_fifo
#(
    parameter int DEPTH = cc_pkg::REQ_QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cc_pkg::cc_req_t  req,
    input  logic             rd_en,
    output cc_pkg::cc_word_t rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cc_pkg::cc_word_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = req.wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= req.counter;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/cc_core.sv -----
// Round engine: one ChaCha round per cycle, final add, then eight 64-bit words out.
// Depends on cc_pkg.
`timescale 1ns / 1ps

module cc_core
#(
    parameter int ROUNDS = cc_pkg::ROUNDS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cc_pkg::cc_cfg_t  cfg,
    input  logic             q_empty,
    input  logic [31:0]      q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [63:0]      keystream_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    localparam int RND_W = $clog2(ROUNDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } core_state_t;

    core_state_t       state_reg;
    core_state_t       state_next;
    logic [RND_W-1:0]  rnd_reg;
    logic [RND_W-1:0]  rnd_next;
    logic [2:0]        idx_reg;
    logic [2:0]        idx_next;
    logic [31:0]       ctr_reg;
    cc_pkg::cc_state_t work_reg;
    cc_pkg::cc_state_t work_next;
    cc_pkg::cc_state_t init_st;
    logic              load;
    logic              out_take;

    assign out_take = (state_reg == ST_OUT) && pop;
    assign load     = !q_empty && ((state_reg == ST_IDLE) ||
                      (out_take && (idx_reg == cc_pkg::LAST_WORD_IDX)));
    assign q_pop    = load;
    assign init_st  = cc_pkg::cc_init(cfg, ctr_reg);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        work_next  = work_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_ROUND:
            begin
                work_next = cc_pkg::cc_round(work_reg, rnd_reg[0]);
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(ROUNDS - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                for (int i = 0; i < cc_pkg::NUM_WORDS; i++) begin
                    work_next[i] = work_reg[i] + init_st[i];
                end
                idx_next   = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (pop) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == cc_pkg::LAST_WORD_IDX) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load) begin
            work_next  = cc_pkg::cc_init(cfg, q_data);
            rnd_next   = '0;
            state_next = ST_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (load) begin
            ctr_reg <= q_data;
        end
    end

    assign empty          = (state_reg != ST_OUT);
    assign keystream_word = {work_reg[{idx_reg, 1'b1}], work_reg[{idx_reg, 1'b0}]};
    assign word_index     = idx_reg;
    assign last_word      = (idx_reg == cc_pkg::LAST_WORD_IDX);

endmodule
